@@ rtl/tch_pkg.sv @@
`default_nettype none

package tch_pkg;

  localparam int SampleWidth   = 32;
  localparam int TimeWidth     = 32;
  localparam int ThreshWidth   = 31;
  localparam int IntervalWidth = 16;
  localparam int CfgDataWidth  = 31;
  localparam int CfgIndexWidth = 1;
  localparam int DeadlineWidth = TimeWidth + 1;

  localparam logic [IntervalWidth-1:0] FireIntervalReset = 16'd200;

  localparam logic [1:0] MODE_TICK      = 2'd0;
  localparam logic [1:0] MODE_TEST      = 2'd1;
  localparam logic [1:0] MODE_TEST_HOLD = 2'd2;

  localparam logic [CfgIndexWidth-1:0] CFG_THRESHOLD     = 1'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_FIRE_INTERVAL = 1'd1;

  typedef enum logic [1:0] {
    CMP_NONE    = 2'd0,
    CMP_LESS    = 2'd1,
    CMP_EQUAL   = 2'd2,
    CMP_GREATER = 2'd3
  } cmp_t;

  typedef struct packed {
    logic                          velocity_valid;
    logic signed [SampleWidth-1:0] velocity;
    logic                          event_valid;
    logic                          less;
    logic                          less_equal;
    logic                          greater;
    logic                          greater_equal;
    logic                          equal;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/tch_cmp.sv @@
`default_nettype none

module tch_cmp
  import tch_pkg::*;
(
  input  wire logic signed [SampleWidth-1:0] sample,
  input  wire logic        [ThreshWidth-1:0] threshold,
  output cmp_t                               code
);

  logic signed [SampleWidth:0] s_ext;
  logic signed [SampleWidth:0] t_ext;

  // both sides at 33 bits, threshold zero-extended so it stays non-negative
  assign s_ext = {sample[SampleWidth-1], sample};
  assign t_ext = {{(SampleWidth + 1 - ThreshWidth){1'b0}}, threshold};

  always_comb begin
    if (s_ext > t_ext) begin
      code = CMP_GREATER;
    end else if (s_ext == t_ext) begin
      code = CMP_EQUAL;
    end else begin
      code = CMP_LESS;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tch_ctrl.sv @@
`default_nettype none

module tch_ctrl
  import tch_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire logic [1:0]                    mode,
  input  wire logic                          target_present,
  input  wire logic signed [SampleWidth-1:0] sample,
  input  wire logic [TimeWidth-1:0]          now,
  input  wire logic [IntervalWidth-1:0]      fire_interval,
  input  wire cmp_t                          code,
  output res_t                               res
);

  cmp_t                     last_compare_r, last_compare_nxt;
  cmp_t                     last_fired_r, last_fired_nxt;
  logic [DeadlineWidth-1:0] deadline_r, deadline_nxt;
  logic                     armed_r, armed_nxt;
  logic [SampleWidth-1:0]   last_velocity_r, last_velocity_nxt;

  logic [DeadlineWidth-1:0] new_deadline;
  logic                     due;
  logic                     fire;
  cmp_t                     fire_code;
  logic                     report;

  assign new_deadline = {1'b0, now} + {{(DeadlineWidth - IntervalWidth){1'b0}}, fire_interval};
  assign due          = armed_r && ({1'b0, now} >= deadline_r);

  always_comb begin
    last_compare_nxt  = last_compare_r;
    last_fired_nxt    = last_fired_r;
    deadline_nxt      = deadline_r;
    armed_nxt         = armed_r;
    last_velocity_nxt = last_velocity_r;
    fire              = 1'b0;
    fire_code         = code;
    report            = 1'b0;

    case (mode)
      MODE_TICK: begin
        if (target_present) begin
          report = 1'b1;
          if (code != last_compare_r) begin
            if (code == last_fired_r) begin
              // back at the result that last fired: drop the deadline
              armed_nxt    = 1'b0;
              deadline_nxt = '0;
            end else if (last_compare_r != CMP_NONE) begin
              armed_nxt    = 1'b1;
              deadline_nxt = new_deadline;
            end
            last_compare_nxt = code;
          end else if (due) begin
            fire           = 1'b1;
            last_fired_nxt = code;
            armed_nxt      = 1'b0;
            deadline_nxt   = '0;
          end
        end
      end
      MODE_TEST: begin
        fire = 1'b1;
        if (!target_present) begin
          fire_code = CMP_EQUAL;
        end
      end
      MODE_TEST_HOLD: begin
        if (target_present) begin
          report           = 1'b1;
          armed_nxt        = 1'b1;
          deadline_nxt     = new_deadline;
          last_fired_nxt   = CMP_NONE;
          last_compare_nxt = code;
        end
      end
      default: begin
      end
    endcase

    report = report && (sample != last_velocity_r);
    if (report) begin
      last_velocity_nxt = sample;
    end

    res                = '0;
    res.velocity_valid = report;
    res.velocity       = report ? sample : '0;
    res.event_valid    = fire;
    if (fire) begin
      case (fire_code)
        CMP_LESS: begin
          res.less       = 1'b1;
          res.less_equal = 1'b1;
        end
        CMP_GREATER: begin
          res.greater       = 1'b1;
          res.greater_equal = 1'b1;
        end
        default: begin
          res.equal         = 1'b1;
          res.less_equal    = 1'b1;
          res.greater_equal = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_compare_r  <= CMP_NONE;
      last_fired_r    <= CMP_NONE;
      deadline_r      <= '0;
      armed_r         <= 1'b0;
      last_velocity_r <= '0;
    end else if (step) begin
      last_compare_r  <= last_compare_nxt;
      last_fired_r    <= last_fired_nxt;
      deadline_r      <= deadline_nxt;
      armed_r         <= armed_nxt;
      last_velocity_r <= last_velocity_nxt;
    end
  end

`ifndef SYNTH
  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(armed_r) && $stable(deadline_r) && $stable(last_compare_r))
    else $error("debounce state moved without a transfer");

  a_armed_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> last_compare_r != CMP_NONE)
    else $error("deadline armed with no compare result");

  a_disarmed_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> deadline_r == '0)
    else $error("deadline left set while disarmed");

  a_fire_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    step && fire && mode == MODE_TICK |=> !armed_r)
    else $error("tick fire did not disarm");
`endif

endmodule

`default_nettype wire

@@ rtl/threshold_compare_holdoff.sv @@
// Path: an item enters the input register, then moves into the result register,
// and its result can transfer only from there.
// Throughput: one item per cycle unless a held result (out_ready low) stalls it;
// the debounce state updates in the same cycle that an item enters the result register.
// Reset (synchronous, rst_n low): pipeline empty, no result and no fire history,
// deadline disarmed, last velocity 0, threshold 0, fire interval 200 ms.
`default_nettype none

module threshold_compare_holdoff
  import tch_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          cfg_we,
  input  wire logic [CfgIndexWidth-1:0]      cfg_index,
  input  wire logic [CfgDataWidth-1:0]       cfg_wdata,

  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_mode,
  input  wire logic                          in_target_present,
  input  wire logic signed [SampleWidth-1:0] in_sample,
  input  wire logic [TimeWidth-1:0]          in_now,

  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_velocity_valid,
  output logic signed [SampleWidth-1:0]      out_velocity,
  output logic                               out_event_valid,
  output logic                               out_less,
  output logic                               out_less_equal,
  output logic                               out_greater,
  output logic                               out_greater_equal,
  output logic                               out_equal
);

  logic [ThreshWidth-1:0]   threshold_r;
  logic [IntervalWidth-1:0] fire_interval_r;

  logic                          in_valid_r, in_valid_nxt;
  logic [1:0]                    mode_r;
  logic                          target_present_r;
  logic signed [SampleWidth-1:0] sample_r;
  logic [TimeWidth-1:0]          now_r;

  logic out_valid_r, out_valid_nxt;
  res_t res_r;
  res_t res;
  cmp_t code;
  logic advance;
  logic in_xfer;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r     <= '0;
      fire_interval_r <= FireIntervalReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:     threshold_r     <= cfg_wdata[ThreshWidth-1:0];
        CFG_FIRE_INTERVAL: fire_interval_r <= cfg_wdata[IntervalWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r           <= in_mode;
      target_present_r <= in_target_present;
      sample_r         <= in_sample;
      now_r            <= in_now;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  tch_cmp u_cmp (
    .sample    (sample_r),
    .threshold (threshold_r),
    .code      (code)
  );

  tch_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .mode           (mode_r),
    .target_present (target_present_r),
    .sample         (sample_r),
    .now            (now_r),
    .fire_interval  (fire_interval_r),
    .code           (code),
    .res            (res)
  );

  assign out_valid          = out_valid_r;
  assign out_velocity_valid = res_r.velocity_valid;
  assign out_velocity       = res_r.velocity;
  assign out_event_valid    = res_r.event_valid;
  assign out_less           = res_r.less;
  assign out_less_equal     = res_r.less_equal;
  assign out_greater        = res_r.greater;
  assign out_greater_equal  = res_r.greater_equal;
  assign out_equal          = res_r.equal;

`ifndef SYNTH
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while both stages are held");

  a_event_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_event_valid |-> $onehot({out_less, out_equal, out_greater}))
    else $error("fired result is not exactly one of less, equal, greater");

  a_no_event_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_event_valid |->
      !(out_less || out_less_equal || out_greater || out_greater_equal || out_equal))
    else $error("compare flags set without an event");
`endif

endmodule

`default_nettype wire
